### sv/jvpd_pkg.sv
`default_nettype none

package jvpd_pkg;

   // joint number field on the request word
   localparam int JOINT_W = 3;

   // rows in the fixed gain tables
   localparam int GAIN_SLOTS = 6;

   // gain widths: kp up to 400, kd/T up to 50
   localparam int KP_W  = 9;
   localparam int KDR_W = 6;

   // drive value, Q16.16
   localparam int DRIVE_W = 32;

   typedef logic [JOINT_W-1:0]        joint_type;
   typedef logic [KP_W-1:0]           kp_type;
   typedef logic [KDR_W-1:0]          kdr_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;

   localparam drive_type DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
   localparam drive_type DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

   // proportional gain per joint
   localparam kp_type KP_TABLE [GAIN_SLOTS] = '{
      KP_W'(300), KP_W'(400), KP_W'(250), KP_W'(100), KP_W'(120), KP_W'(80)
   };

   // derivative gain over the 1 ms sample period
   localparam kdr_type KDR_TABLE [GAIN_SLOTS] = '{
      KDR_W'(0), KDR_W'(50), KDR_W'(10), KDR_W'(50), KDR_W'(50), KDR_W'(50)
   };

endpackage

`default_nettype wire

### sv/jvpd_req_if.sv
`default_nettype none

interface jvpd_req_if
   import jvpd_pkg::*;
#(
   parameter int VEL_WIDTH = 24
);

   logic                        valid;
   logic                        ready;
   joint_type                   joint_index;
   logic signed [VEL_WIDTH-1:0] ref_vel;
   logic signed [VEL_WIDTH-1:0] meas_vel;

   modport source (output valid, output joint_index, output ref_vel, output meas_vel,
                   input ready);
   modport sink   (input valid, input joint_index, input ref_vel, input meas_vel,
                   output ready);

endinterface

`default_nettype wire

### sv/jvpd_rsp_if.sv
`default_nettype none

interface jvpd_rsp_if
   import jvpd_pkg::*;
();

   logic      valid;
   logic      ready;
   drive_type drive_out;
   logic      saturated;

   modport source (output valid, output drive_out, output saturated, input ready);
   modport sink   (input valid, input drive_out, input saturated, output ready);

endinterface

`default_nettype wire

### sv/joint_velocity_pd_controller.sv
// channel   dir  modport  word contents
// --------  ---  -------  -------------------------------------------------
// req_bus   in   sink     joint_index[3], ref_vel[VEL_WIDTH], meas_vel[VEL_WIDTH]
// rsp_bus   out  source   drive_out[32] (Q16.16), saturated[1]
//
// One word per cycle unless rsp stalls; words pass stage then result register.
// The stage register feeds the PD arithmetic and the per-joint history read,
// the result register holds the drive word until taken.
// Synchronous active-high reset clears the valid flags and the seen bits.
// A stalled rsp holds the result; the stage behind it keeps one word, so
// req_bus.ready drops only when both stages are full and rsp is stalled.

`default_nettype none

module joint_velocity_pd_controller
   import jvpd_pkg::*;
#(
   parameter int NUM_JOINTS = 6,
   parameter int VEL_WIDTH  = 24
) (
   input  wire        clock,
   input  wire        reset,
   jvpd_req_if.sink   req_bus,
   jvpd_rsp_if.source rsp_bus
);

   localparam int IDX_W  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int DIFF_W = VEL_WIDTH + 1;
   // diff times a 10-bit signed gain
   localparam int PROD_W = VEL_WIDTH + 11;
   localparam int SUM_W  = (VEL_WIDTH + 12 > DRIVE_W + 1) ? VEL_WIDTH + 12 : DRIVE_W + 1;

   // ---- stage register: accepted word ----
   logic                        s1_valid_ff, s1_valid_in;
   joint_type                   s1_joint_ff;
   logic signed [VEL_WIDTH-1:0] s1_ref_ff;
   logic signed [VEL_WIDTH-1:0] s1_meas_ff;

   // ---- result register ----
   logic      rsp_valid_ff, rsp_valid_in;
   drive_type drive_ff, drive_in;
   logic      sat_ff, sat_in;

   // ---- per-joint history ----
   logic [VEL_WIDTH-1:0]  last_vel_ff [NUM_JOINTS];
   logic [NUM_JOINTS-1:0] joint_seen_ff, joint_seen_in;

   logic s1_advance;
   logic req_take;
   logic in_range;
   logic [IDX_W-1:0] s1_idx;

   logic signed [VEL_WIDTH-1:0] prev_vel;
   logic signed [DIFF_W-1:0]    err_diff;
   logic signed [DIFF_W-1:0]    rate_diff;
   logic signed [KP_W:0]        kp_s;
   logic signed [KDR_W:0]       kdr_s;
   logic signed [PROD_W-1:0]    p_term;
   logic signed [PROD_W-1:0]    d_term;
   logic signed [SUM_W-1:0]     pd_sum;
   logic [SUM_W-DRIVE_W:0]      sum_top;
   logic                        sum_fits;

   // handshake: stage moves on when the result register is free or being emptied
   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_range = (s1_joint_ff < JOINT_W'(NUM_JOINTS));
   assign s1_idx   = s1_joint_ff[IDX_W-1:0];

   // first sample of a joint: previous equals current, so no derivative kick
   always_comb begin
      if (in_range && joint_seen_ff[s1_idx]) begin
         prev_vel = $signed(last_vel_ff[s1_idx]);
      end else begin
         prev_vel = s1_meas_ff;
      end
   end

   always_comb begin
      if (in_range) begin
         kp_s  = $signed({1'b0, KP_TABLE[s1_joint_ff]});
         kdr_s = $signed({1'b0, KDR_TABLE[s1_joint_ff]});
      end else begin
         kp_s  = '0;
         kdr_s = '0;
      end
   end

   assign err_diff  = DIFF_W'(s1_ref_ff) - DIFF_W'(s1_meas_ff);
   assign rate_diff = DIFF_W'(s1_meas_ff) - DIFF_W'(prev_vel);

   assign p_term = PROD_W'(err_diff) * PROD_W'(kp_s);
   assign d_term = PROD_W'(rate_diff) * PROD_W'(kdr_s);
   assign pd_sum = SUM_W'(p_term) + SUM_W'(d_term);

   // fits in 32 bits when everything from bit 31 upwards is pure sign
   assign sum_top  = pd_sum[SUM_W-1:DRIVE_W-1];
   assign sum_fits = (sum_top == '0) || (sum_top == '1);

   always_comb begin
      if (!in_range) begin
         drive_in = '0;
         sat_in   = 1'b0;
      end else if (sum_fits) begin
         drive_in = pd_sum[DRIVE_W-1:0];
         sat_in   = 1'b0;
      end else if (pd_sum[SUM_W-1]) begin
         drive_in = DRIVE_MIN;
         sat_in   = 1'b1;
      end else begin
         drive_in = DRIVE_MAX;
         sat_in   = 1'b1;
      end
   end

   always_comb begin
      joint_seen_in = joint_seen_ff;
      if (s1_advance && in_range) begin
         joint_seen_in[s1_idx] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         joint_seen_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         joint_seen_ff <= joint_seen_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_joint_ff <= req_bus.joint_index;
         s1_ref_ff   <= req_bus.ref_vel;
         s1_meas_ff  <= req_bus.meas_vel;
      end
      if (s1_advance) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
      if (s1_advance && in_range) begin
         last_vel_ff[s1_idx] <= s1_meas_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.drive_out = drive_ff;
   assign rsp_bus.saturated = sat_ff;

`ifndef ASSERT_OFF
   a_reset_clears_seen: assert property (@(posedge clock)
      reset |=> (joint_seen_ff == '0))
      else $error("seen bits not cleared by reset");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> ((drive_ff == DRIVE_MAX) || (drive_ff == DRIVE_MIN)))
      else $error("saturated flag without a clipped drive value");

   a_bad_joint_no_state: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !in_range) |=> $stable(joint_seen_ff))
      else $error("out-of-range joint changed the history");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("request held off without a full stalled pipe");

   a_seen_after_sample: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && in_range) |=> joint_seen_ff[$past(s1_idx)])
      else $error("joint not marked seen after its sample");
`endif

endmodule

`default_nettype wire
